// ===== sv/pnsc_pkg.sv =====
package pnsc_pkg;

  // Canvas and palette geometry.
  localparam int CANVAS_SIZE   = 220;
  localparam int PALETTE_DEPTH = 256;
  localparam int MAX_RESULTS   = 8;

  // Field widths fixed by the interface.
  localparam int OP_W       = 1;
  localparam int IDX_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int ROW_W      = 10;
  localparam int COORD_W    = 8;
  localparam int SCALE_W    = 15;
  localparam int INV_W      = 24;
  localparam int OFS_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Fixed-point formats.
  localparam int SCALE_FRAC = 14;
  localparam int INV_FRAC   = 12;

  // Derived widths.
  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int COL_W  = $clog2(CANVAS_SIZE + 1);
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int GEO_W  = 12;
  localparam int CX_W   = 13;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PALETTE = 1'b0;
  localparam logic [OP_W-1:0] OP_PIXEL   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y   = 3'd4;

  // Per-row geometry handed from the geometry unit to the column loop.
  typedef struct packed {
    logic [COL_W-1:0] ow;
    logic [GEO_W-1:0] ox_base;
    logic [GEO_W-1:0] oy_base;
    logic             two_rows;
  } geom_t;

endpackage

// ===== sv/pnsc_in_if.sv =====
interface pnsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pnsc_pkg::OP_W-1:0]     operation;
  logic [pnsc_pkg::IDX_W-1:0]    palette_address;
  logic [pnsc_pkg::COLOR_W-1:0]  palette_color;
  logic [pnsc_pkg::ROW_W-1:0]    row_y;
  logic [pnsc_pkg::ROW_W-1:0]    row_left;
  logic [pnsc_pkg::ROW_W-1:0]    row_width;
  logic [pnsc_pkg::IDX_W-1:0]    pixel_index;
  logic                          has_transparency;
  logic [pnsc_pkg::IDX_W-1:0]    transparent_index;
  logic                          last_pixel;

  modport source (
    output valid, operation, palette_address, palette_color, row_y, row_left,
           row_width, pixel_index, has_transparency, transparent_index, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, operation, palette_address, palette_color, row_y, row_left,
           row_width, pixel_index, has_transparency, transparent_index, last_pixel,
    output ready
  );
endinterface

// ===== sv/pnsc_out_if.sv =====
interface pnsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pnsc_pkg::COORD_W-1:0]  out_x;
  logic [pnsc_pkg::COORD_W-1:0]  out_y;
  logic [pnsc_pkg::COLOR_W-1:0]  out_color;
  logic                          last_of_run;

  modport source (
    output valid, out_x, out_y, out_color, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_color, last_of_run,
    output ready
  );
endinterface

// ===== sv/pnsc_row_geom.sv =====
module pnsc_row_geom (
  input  logic                          clk_i,
  input  logic [pnsc_pkg::ROW_W-1:0]    row_y_i,
  input  logic [pnsc_pkg::ROW_W-1:0]    row_left_i,
  input  logic [pnsc_pkg::ROW_W-1:0]    row_width_i,
  input  logic [pnsc_pkg::SCALE_W-1:0]  scale_i,
  input  logic [pnsc_pkg::OFS_W-1:0]    offset_x_i,
  input  logic [pnsc_pkg::OFS_W-1:0]    offset_y_i,
  output pnsc_pkg::geom_t               geom_o
);
  import pnsc_pkg::*;

  localparam int PROD_W = ROW_W + SCALE_W;

  logic [ROW_W:0]    right_edge;
  logic [PROD_W-1:0] prod_y_q;
  logic [PROD_W-1:0] prod_l_q;
  logic [PROD_W:0]   prod_r_q;

  logic [PROD_W:0]   prod_y1;
  logic [GEO_W-1:0]  oy0;
  logic [GEO_W-1:0]  oy1;
  logic [GEO_W-1:0]  row_span;
  logic [GEO_W-1:0]  ox0;
  logic [GEO_W-1:0]  ox1;
  logic [GEO_W-1:0]  ow_raw;
  geom_t             geom_d;
  geom_t             geom_q;

  assign right_edge = (ROW_W + 1)'(row_left_i) + (ROW_W + 1)'(row_width_i);

  // First stage: the three scale products.
  always_ff @(posedge clk_i) begin
    prod_y_q <= PROD_W'(row_y_i) * PROD_W'(scale_i);
    prod_l_q <= PROD_W'(row_left_i) * PROD_W'(scale_i);
    prod_r_q <= (PROD_W + 1)'(right_edge) * (PROD_W + 1)'(scale_i);
  end

  // (row_y + 1) * scale is the row product plus one more scale step.
  assign prod_y1 = (PROD_W + 1)'(prod_y_q) + (PROD_W + 1)'(scale_i);

  always_comb begin
    oy0      = GEO_W'(prod_y_q[PROD_W-1:SCALE_FRAC]);
    oy1      = GEO_W'(prod_y1[PROD_W:SCALE_FRAC]);
    row_span = oy1 - oy0;
    ox0      = GEO_W'(prod_l_q[PROD_W-1:SCALE_FRAC]);
    ox1      = GEO_W'(prod_r_q[PROD_W:SCALE_FRAC]);
    ow_raw   = ox1 - ox0;

    geom_d.two_rows = (row_span >= GEO_W'(2));
    if (ow_raw > GEO_W'(CANVAS_SIZE)) begin
      geom_d.ow = COL_W'(CANVAS_SIZE);
    end else begin
      geom_d.ow = COL_W'(ow_raw);
    end
    geom_d.ox_base = GEO_W'(offset_x_i) + ox0;
    geom_d.oy_base = GEO_W'(offset_y_i) + oy0;
  end

  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  assign geom_o = geom_q;

endmodule

// ===== sv/palette_scanline_nearest_scaler.sv =====
// Channel   Port   Direction  Carries
// -------   ----   ---------  --------------------------------------------
// input     pix_i  sink       palette write or one source row pixel
// output    res_o  source     canvas x, canvas y, color, last of the run
// config    cfg_*  write      scale, inverse scale, background, offsets
//
// A pixel first passes setup (palette read, scale products, row geometry), then
// the column loop steps through each row of a claimed column that lies on the
// canvas, each column that falls off it, and the column that ends the loop, then
// a flush; the column loop shares one sample multiplier.
// Reset is asynchronous: it clears control state, row position and result registers
// and loads unit scale and inverse scale; palette contents stay undefined until written.
// A result sits in a pending stage until the next one or the end of the run is
// known; the loop holds when a new result finds it full and the output register full and not taken.
module palette_scanline_nearest_scaler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pnsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pnsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  pnsc_in_if.sink                         pix_i,
  pnsc_out_if.source                      res_o
);
  import pnsc_pkg::*;

  localparam int SX_W = COL_W + INV_W - INV_FRAC;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEOM,
    ST_SETUP,
    ST_COLUMN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [ROW_W-1:0] row_y;
    logic [ROW_W-1:0] row_left;
    logic [ROW_W-1:0] row_width;
    logic [IDX_W-1:0] pixel_index;
    logic             has_transparency;
    logic [IDX_W-1:0] transparent_index;
    logic             last_pixel;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COLOR_W-1:0] out_color;
  } res_t;

  state_e             state_q;
  item_t              item_q;
  logic [SCALE_W-1:0] scale_q;
  logic [INV_W-1:0]   inv_q;
  logic [COLOR_W-1:0] bg_q;
  logic [OFS_W-1:0]   offset_x_q;
  logic [OFS_W-1:0]   offset_y_q;
  logic [ROW_W-1:0]   pos_q;
  logic [COL_W-1:0]   next_col_q;
  logic [COL_W-1:0]   col_q;
  logic               row_q;
  logic [CNT_W-1:0]   n_q;
  logic [COLOR_W-1:0] color_q;
  res_t               pend_q;
  logic               pend_v_q;
  res_t               res_q;
  logic               res_v_q;
  logic               res_last_q;

  logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] pal_rdata_q;

  geom_t              geom;
  logic               in_acc;
  logic               pal_we;
  logic               pal_re;
  logic [COLOR_W-1:0] color_sel;

  logic [COL_W+INV_W-1:0] samp_prod;
  logic [SX_W-1:0]        sx;
  logic [SX_W-1:0]        width_ext;
  logic [SX_W-1:0]        sx_c;
  logic [CX_W-1:0]        cx;
  logic [CX_W-1:0]        cy;
  logic                   in_range;
  logic                   stop;
  logic                   col_vis;
  logic                   row_vis;
  logic                   emit;
  logic                   out_free;
  logic                   stall;
  logic                   last_row;
  logic                   res_load;
  res_t                   new_res;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign in_acc      = pix_i.valid && pix_i.ready;
  assign pal_we      = in_acc && (pix_i.operation == OP_PALETTE) &&
                       ((IDX_W + 1)'(pix_i.palette_address) < (IDX_W + 1)'(PALETTE_DEPTH));
  assign pal_re      = in_acc && (pix_i.operation == OP_PIXEL);

  // A write lands at its acceptance edge and the next pixel is accepted no
  // earlier than the following cycle, so the read always sees it.
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      palette_mem[pix_i.palette_address[PAL_AW-1:0]] <= pix_i.palette_color;
    end
    if (pal_re) begin
      pal_rdata_q <= palette_mem[pix_i.pixel_index[PAL_AW-1:0]];
    end
  end

  pnsc_row_geom u_row_geom (
    .clk_i       (clk_i),
    .row_y_i     (item_q.row_y),
    .row_left_i  (item_q.row_left),
    .row_width_i (item_q.row_width),
    .scale_i     (scale_q),
    .offset_x_i  (offset_x_q),
    .offset_y_i  (offset_y_q),
    .geom_o      (geom)
  );

  always_comb begin
    if (item_q.has_transparency && (item_q.pixel_index == item_q.transparent_index)) begin
      color_sel = bg_q;
    end else if ((IDX_W + 1)'(item_q.pixel_index) < (IDX_W + 1)'(PALETTE_DEPTH)) begin
      color_sel = pal_rdata_q;
    end else begin
      color_sel = '0;
    end
  end

  // Column loop: sample position of the current column and its clipping.
  always_comb begin
    samp_prod = (COL_W + INV_W)'(col_q) * (COL_W + INV_W)'(inv_q);
    sx        = samp_prod[COL_W+INV_W-1:INV_FRAC];
    width_ext = SX_W'(item_q.row_width);
    if ((item_q.row_width != '0) && (sx >= width_ext)) begin
      sx_c = width_ext - SX_W'(1);
    end else begin
      sx_c = sx;
    end
    in_range  = (col_q < geom.ow);
    stop      = !in_range || (!item_q.last_pixel && (sx_c > SX_W'(pos_q)));
    cx        = CX_W'(geom.ox_base) + CX_W'(col_q);
    cy        = CX_W'(geom.oy_base) + CX_W'(row_q);
    col_vis   = (cx < CX_W'(CANVAS_SIZE));
    row_vis   = (cy < CX_W'(CANVAS_SIZE));
    emit      = !stop && col_vis && row_vis && (n_q < CNT_W'(MAX_RESULTS));
    out_free  = !res_v_q || res_o.ready;
    stall     = emit && pend_v_q && !out_free;
    last_row  = !geom.two_rows || row_q;
    res_load  = ((state_q == ST_COLUMN) && emit && pend_v_q && !stall) ||
                ((state_q == ST_FLUSH) && pend_v_q && out_free);

    new_res.out_x     = cx[COORD_W-1:0];
    new_res.out_y     = cy[COORD_W-1:0];
    new_res.out_color = color_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      item_q     <= '0;
      scale_q    <= SCALE_W'(16384);
      inv_q      <= INV_W'(4096);
      bg_q       <= '0;
      offset_x_q <= '0;
      offset_y_q <= '0;
      pos_q      <= '0;
      next_col_q <= '0;
      col_q      <= '0;
      row_q      <= 1'b0;
      n_q        <= '0;
      color_q    <= '0;
      pend_q     <= '0;
      pend_v_q   <= 1'b0;
      res_q      <= '0;
      res_v_q    <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SCALE:      scale_q    <= cfg_wdata_i[SCALE_W-1:0];
          CFG_INV_SCALE:  inv_q      <= cfg_wdata_i[INV_W-1:0];
          CFG_BACKGROUND: bg_q       <= cfg_wdata_i[COLOR_W-1:0];
          CFG_OFFSET_X:   offset_x_q <= cfg_wdata_i[OFS_W-1:0];
          CFG_OFFSET_Y:   offset_y_q <= cfg_wdata_i[OFS_W-1:0];
          default: ;
        endcase
      end

      if (res_v_q && res_o.ready && !res_load) begin
        res_v_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (pix_i.operation == OP_PIXEL)) begin
            item_q.row_y             <= pix_i.row_y;
            item_q.row_left          <= pix_i.row_left;
            item_q.row_width         <= pix_i.row_width;
            item_q.pixel_index       <= pix_i.pixel_index;
            item_q.has_transparency  <= pix_i.has_transparency;
            item_q.transparent_index <= pix_i.transparent_index;
            item_q.last_pixel        <= pix_i.last_pixel;
            state_q                  <= ST_GEOM;
          end
        end
        ST_GEOM: begin
          color_q <= color_sel;
          state_q <= ST_SETUP;
        end
        ST_SETUP: begin
          col_q   <= next_col_q;
          row_q   <= 1'b0;
          n_q     <= '0;
          state_q <= ST_COLUMN;
        end
        ST_COLUMN: begin
          if (stop) begin
            if (item_q.last_pixel) begin
              pos_q      <= '0;
              next_col_q <= '0;
            end else begin
              pos_q      <= pos_q + ROW_W'(1);
              next_col_q <= col_q;
            end
            state_q <= ST_FLUSH;
          end else if (!stall) begin
            if (emit) begin
              if (pend_v_q) begin
                res_q      <= pend_q;
                res_last_q <= 1'b0;
                res_v_q    <= 1'b1;
              end
              pend_q   <= new_res;
              pend_v_q <= 1'b1;
              n_q      <= n_q + CNT_W'(1);
            end
            // A clipped column is skipped as a whole.
            if (col_vis && !last_row) begin
              row_q <= 1'b1;
            end else begin
              row_q <= 1'b0;
              col_q <= col_q + COL_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            res_q      <= pend_q;
            res_last_q <= 1'b1;
            res_v_q    <= 1'b1;
            pend_v_q   <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid       = res_v_q;
  assign res_o.out_x       = res_q.out_x;
  assign res_o.out_y       = res_q.out_y;
  assign res_o.out_color   = res_q.out_color;
  assign res_o.last_of_run = res_last_q;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending result left behind when the block went idle");

  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(MAX_RESULTS))
    else $error("result count passed its cap");

  a_column_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_W'(CANVAS_SIZE)) && (next_col_q <= COL_W'(CANVAS_SIZE)))
    else $error("column counter ran past the canvas");

  a_out_from_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_v_q) |-> $past(pend_v_q))
    else $error("output loaded without a pending result");
`endif

endmodule
